// ----- rtl/line_pixel_stepper_defines.svh -----
// Assertion macros shared by the line pixel stepper RTL.
// Included by files that carry concurrent assertions; needs aclk and aresetn in scope.
`ifndef LINE_PIXEL_STEPPER_DEFINES_SVH
`define LINE_PIXEL_STEPPER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lps_pkg.sv -----
// Shared constants and types for the line pixel stepper.
// No dependencies; imported by every module of the block.
package lps_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ROW_SHIFT_DEF  = 10;

    localparam int SIZE_BITS   = 10;
    localparam int ADDR_BITS   = 32;
    localparam int COLOR_BITS  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [ADDR_BITS-1:0] BASE_RESET   = 32'hC000_0000;
    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 10'd320;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 10'd240;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BUFFER_BASE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd2;

    // request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    // decoded command flags, front to back
    typedef struct packed {
        logic is_start;
        logic active;
        logic steep;
        logic dir_neg;
    } cmd_flags_t;

    localparam int CMD_FLAG_BITS = $bits(cmd_flags_t);

    // per-pixel flags, stepper to pixel output
    typedef struct packed {
        logic last;
        logic none;
    } pix_flags_t;

endpackage

// ----- rtl/lps_front.sv -----
// Front end: input register and line setup decode (steep test, endpoint order, deltas).
// Depends on lps_pkg; feeds the command queue.
module lps_front
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_req_type,
    input  logic signed [COORD_BITS-1:0] in_start_x,
    input  logic signed [COORD_BITS-1:0] in_start_y,
    input  logic signed [COORD_BITS-1:0] in_end_x,
    input  logic signed [COORD_BITS-1:0] in_end_y,
    input  logic [COLOR_BITS-1:0]        in_color,
    output logic                         q_valid,
    input  logic                         q_ready,
    output cmd_flags_t                   q_flags,
    output logic signed [COORD_BITS-1:0] q_major_pos,
    output logic signed [COORD_BITS-1:0] q_major_stop,
    output logic signed [COORD_BITS-1:0] q_minor_pos,
    output logic [COORD_BITS-1:0]        q_major_delta,
    output logic [COORD_BITS-1:0]        q_minor_delta,
    output logic signed [COORD_BITS-1:0] q_error,
    output logic [COLOR_BITS-1:0]        q_color
);

    localparam int C = COORD_BITS;

    logic                valid_reg;
    logic                type_reg;
    logic signed [C-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [C:0]   dx_reg, dy_reg;
    logic [COLOR_BITS-1:0] color_reg;

    logic signed [C:0] dx_next, dy_next;
    logic        [C:0] adx, ady, amaj, amin, half_maj;
    logic signed [C:0] dmaj, dmin, neg_half;
    logic              steep, rev;
    logic signed [C-1:0] a_maj, b_maj, a_min, b_min;

    assign in_ready = !valid_reg || q_ready;

    assign dx_next = $signed({in_end_x[C-1], in_end_x}) - $signed({in_start_x[C-1], in_start_x});
    assign dy_next = $signed({in_end_y[C-1], in_end_y}) - $signed({in_start_y[C-1], in_start_y});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            type_reg  <= in_req_type;
            ax_reg    <= in_start_x;
            ay_reg    <= in_start_y;
            bx_reg    <= in_end_x;
            by_reg    <= in_end_y;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            color_reg <= in_color;
        end
    end

    // setup decode from the registered request
    always_comb begin
        adx   = dx_reg[C] ? $unsigned(-dx_reg) : $unsigned(dx_reg);
        ady   = dy_reg[C] ? $unsigned(-dy_reg) : $unsigned(dy_reg);
        steep = ady > adx;
        dmaj  = steep ? dy_reg : dx_reg;
        dmin  = steep ? dx_reg : dy_reg;
        amaj  = steep ? ady : adx;
        amin  = steep ? adx : ady;
        a_maj = steep ? ay_reg : ax_reg;
        b_maj = steep ? by_reg : bx_reg;
        a_min = steep ? ax_reg : ay_reg;
        b_min = steep ? bx_reg : by_reg;
        rev   = dmaj[C];
        half_maj = {1'b0, amaj[C:1]};
        neg_half = -$signed(half_maj);
    end

    assign q_valid          = valid_reg;
    assign q_flags.is_start = (type_reg == REQ_START);
    assign q_flags.active   = (dmaj != '0);
    assign q_flags.steep    = steep;
    // minor coordinate does not rise from the ordered start to the ordered end
    assign q_flags.dir_neg  = rev ? !dmin[C] : (dmin[C] || (dmin == '0));
    assign q_major_pos      = rev ? b_maj : a_maj;
    assign q_major_stop     = rev ? a_maj : b_maj;
    assign q_minor_pos      = rev ? b_min : a_min;
    assign q_major_delta    = amaj[C-1:0];
    assign q_minor_delta    = amin[C-1:0];
    assign q_error          = neg_half[C-1:0];
    assign q_color          = color_reg;

endmodule

// ----- rtl/lps_queue.sv -----
// Small flip-flop FIFO between the front end and the stepper.
// Depends on lps_pkg for the default depth; depth must be a power of two.
module lps_queue
    import lps_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    entries_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                push, pop;

    assign wr_ready = (count_reg != FULL_COUNT);
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_BITS'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/lps_back.sv -----
// Back end: Bresenham stepper holding the current line state, one step per command.
// Depends on lps_pkg; pops the command queue and feeds lps_pixel_out.
module lps_back
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  cmd_flags_t                   cmd_flags,
    input  logic signed [COORD_BITS-1:0] cmd_major_pos,
    input  logic signed [COORD_BITS-1:0] cmd_major_stop,
    input  logic signed [COORD_BITS-1:0] cmd_minor_pos,
    input  logic [COORD_BITS-1:0]        cmd_major_delta,
    input  logic [COORD_BITS-1:0]        cmd_minor_delta,
    input  logic signed [COORD_BITS-1:0] cmd_error,
    input  logic [COLOR_BITS-1:0]        cmd_color,
    output logic                         pix_valid,
    input  logic                         pix_ready,
    output logic signed [COORD_BITS-1:0] pix_x,
    output logic signed [COORD_BITS-1:0] pix_y,
    output logic [COLOR_BITS-1:0]        pix_color,
    output pix_flags_t                   pix_flags
);

    localparam int C = COORD_BITS;
    localparam logic signed [C:0]   ONE_C1 = 1;
    localparam logic signed [C+1:0] ONE_C2 = 1;

    // line state
    logic                  active_reg;
    logic                  steep_reg;
    logic                  dir_neg_reg;
    logic signed [C-1:0]   major_pos_reg, major_stop_reg, minor_pos_reg;
    logic [C-1:0]          major_delta_reg, minor_delta_reg;
    logic signed [C+1:0]   error_reg;
    logic [COLOR_BITS-1:0] color_reg;

    // pixel register toward the output stages
    logic                  pv_reg;
    logic signed [C-1:0]   px_reg, py_reg;
    logic [COLOR_BITS-1:0] pcolor_reg;
    pix_flags_t            pflags_reg;

    // current source: fresh command on a start, held state otherwise
    logic                  cur_active, cur_steep, cur_dir;
    logic signed [C-1:0]   cur_maj, cur_stop, cur_min;
    logic [C-1:0]          cur_mdel, cur_ndel;
    logic signed [C+1:0]   cur_err;
    logic [COLOR_BITS-1:0] cur_color;

    logic signed [C:0]     maj_inc, stop_ext;
    logic signed [C+1:0]   err_sum, err_next;
    logic signed [C-1:0]   min_next;
    logic                  last, step, take;

    assign cmd_ready = !pv_reg || pix_ready;
    assign take      = cmd_valid && cmd_ready;

    always_comb begin
        if (cmd_flags.is_start) begin
            cur_active = cmd_flags.active;
            cur_steep  = cmd_flags.steep;
            cur_dir    = cmd_flags.dir_neg;
            cur_maj    = cmd_major_pos;
            cur_stop   = cmd_major_stop;
            cur_min    = cmd_minor_pos;
            cur_mdel   = cmd_major_delta;
            cur_ndel   = cmd_minor_delta;
            cur_err    = {{2{cmd_error[C-1]}}, cmd_error};
            cur_color  = cmd_color;
        end else begin
            cur_active = active_reg;
            cur_steep  = steep_reg;
            cur_dir    = dir_neg_reg;
            cur_maj    = major_pos_reg;
            cur_stop   = major_stop_reg;
            cur_min    = minor_pos_reg;
            cur_mdel   = major_delta_reg;
            cur_ndel   = minor_delta_reg;
            cur_err    = error_reg;
            cur_color  = color_reg;
        end
    end

    always_comb begin
        maj_inc  = $signed({cur_maj[C-1], cur_maj}) + ONE_C1;
        stop_ext = $signed({cur_stop[C-1], cur_stop});
        last     = (maj_inc >= stop_ext);
        err_sum  = cur_err + $signed({2'b00, cur_ndel});
        step     = !err_sum[C+1] && (err_sum != '0);
        err_next = step ? (err_sum - $signed({2'b00, cur_mdel})) : err_sum;
        if (!step) begin
            min_next = cur_min;
        end else if (cur_dir) begin
            min_next = cur_min - ONE_C2[C-1:0];
        end else begin
            min_next = cur_min + ONE_C2[C-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (take) begin
            active_reg <= cur_active && !last;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            steep_reg       <= cur_steep;
            dir_neg_reg     <= cur_dir;
            major_stop_reg  <= cur_stop;
            major_delta_reg <= cur_mdel;
            minor_delta_reg <= cur_ndel;
            color_reg       <= cur_color;
            if (cur_active) begin
                major_pos_reg <= maj_inc[C-1:0];
                minor_pos_reg <= min_next;
                error_reg     <= err_next;
            end else begin
                major_pos_reg <= cur_maj;
                minor_pos_reg <= cur_min;
                error_reg     <= cur_err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (cmd_ready) begin
            pv_reg <= cmd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            px_reg          <= cur_steep ? cur_min : cur_maj;
            py_reg          <= cur_steep ? cur_maj : cur_min;
            pcolor_reg      <= cur_color;
            pflags_reg.last <= cur_active && last;
            pflags_reg.none <= !cur_active;
        end
    end

    assign pix_valid = pv_reg;
    assign pix_x     = px_reg;
    assign pix_y     = py_reg;
    assign pix_color = pcolor_reg;
    assign pix_flags = pflags_reg;

endmodule

// ----- rtl/lps_pixel_out.sv -----
// Pixel output pipeline: screen wrap, then off-screen test, address and output register.
// Depends on lps_pkg; drives the result channel of the top level.
module lps_pixel_out
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ROW_SHIFT  = ROW_SHIFT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ADDR_BITS-1:0]         buffer_base,
    input  logic [SIZE_BITS-1:0]         screen_width,
    input  logic [SIZE_BITS-1:0]         screen_height,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic [COLOR_BITS-1:0]        in_color,
    input  pix_flags_t                   in_flags,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic [ADDR_BITS-1:0]         out_addr,
    output logic [COLOR_BITS-1:0]        out_color,
    output logic                         out_last,
    output logic                         out_none,
    output logic                         out_off
);

    localparam int C  = COORD_BITS;
    localparam int WB = COORD_BITS + 2;

    function automatic logic signed [WB-1:0] wrap_once(input logic signed [C-1:0] v,
                                                       input logic [SIZE_BITS-1:0] size);
        logic signed [WB-1:0] ve, se, t;
        begin
            ve = {{(WB-C){v[C-1]}}, v};
            se = $signed({{(WB-SIZE_BITS){1'b0}}, size});
            t  = ve[WB-1] ? (ve + se) : ve;
            return (t >= se) ? (t - se) : t;
        end
    endfunction

    // wrap stage
    logic                  wv_reg;
    logic signed [WB-1:0]  wx_reg, wy_reg;
    logic [COLOR_BITS-1:0] wcolor_reg;
    pix_flags_t            wflags_reg;
    logic                  w_ready;

    // output stage
    logic                  ov_reg;
    logic signed [C-1:0]   ox_reg, oy_reg;
    logic [ADDR_BITS-1:0]  oaddr_reg;
    logic [COLOR_BITS-1:0] ocolor_reg;
    logic                  olast_reg, onone_reg, ooff_reg;

    logic signed [WB-1:0]  w_ext, h_ext;
    logic                  off;
    logic [ADDR_BITS-1:0]  x_word, y_word, addr;

    assign w_ready  = !ov_reg || out_ready;
    assign in_ready = !wv_reg || w_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wv_reg <= 1'b0;
        end else if (in_ready) begin
            wv_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            wx_reg     <= wrap_once(in_x, screen_width);
            wy_reg     <= wrap_once(in_y, screen_height);
            wcolor_reg <= in_color;
            wflags_reg <= in_flags;
        end
    end

    always_comb begin
        w_ext  = $signed({{(WB-SIZE_BITS){1'b0}}, screen_width});
        h_ext  = $signed({{(WB-SIZE_BITS){1'b0}}, screen_height});
        off    = wx_reg[WB-1] || (wx_reg >= w_ext) || wy_reg[WB-1] || (wy_reg >= h_ext);
        x_word = {{(ADDR_BITS-WB){wx_reg[WB-1]}}, wx_reg};
        y_word = {{(ADDR_BITS-WB){wy_reg[WB-1]}}, wy_reg};
        addr   = buffer_base + (y_word << ROW_SHIFT) + (x_word << 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (w_ready) begin
            ov_reg <= wv_reg;
        end
    end

    // a result without a pixel carries all-zero fields
    always_ff @(posedge aclk) begin
        if (wv_reg && w_ready) begin
            onone_reg <= wflags_reg.none;
            if (wflags_reg.none) begin
                ox_reg     <= '0;
                oy_reg     <= '0;
                oaddr_reg  <= '0;
                ocolor_reg <= '0;
                olast_reg  <= 1'b0;
                ooff_reg   <= 1'b0;
            end else begin
                ox_reg     <= wx_reg[C-1:0];
                oy_reg     <= wy_reg[C-1:0];
                oaddr_reg  <= addr;
                ocolor_reg <= wcolor_reg;
                olast_reg  <= wflags_reg.last;
                ooff_reg   <= off;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_addr  = oaddr_reg;
    assign out_color = ocolor_reg;
    assign out_last  = olast_reg;
    assign out_none  = onone_reg;
    assign out_off   = ooff_reg;

endmodule

// ----- rtl/line_pixel_stepper.sv -----
// Line pixel stepper top level: Bresenham rasterizer, one pixel per request.
// Depends on lps_pkg, lps_front, lps_queue, lps_back, lps_pixel_out and the defines header.
//
// Usage:
//   s_ channel: one request per transaction. tuser = req_type (0 start a line,
//   1 next pixel). A start loads both endpoints and the color and yields the
//   first pixel; each next request yields the following pixel of that line.
//   m_ channel: exactly one result per request. tlast marks the final pixel,
//   tuser[0] marks a result with no pixel (empty line or no line active),
//   tuser[1] marks a wrapped coordinate that is still off screen.
//   Config port: cfg_index 0 buffer base, 1 screen width, 2 screen height;
//   write only while no request is in flight.
//   Path: a request passes the input register, queue, stepper register,
//   wrap register and output register before its result is valid.
//   Throughput: one request per cycle while m_tready stays high; the stepper's
//   add-and-compare on the error term is combinational, so requests issue back to back.
//   Reset clears all handshake state and the active line, and loads the
//   register defaults (base 0xC0000000, 320 x 240). When m_tready is low the
//   pipeline fills and the 4-entry command queue absorbs requests before
//   s_tready drops; no result is lost or repeated.
module line_pixel_stepper
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ROW_SHIFT  = ROW_SHIFT_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ADDR_BITS-1:0]    cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // start_x, start_y, end_x, end_y, pixel_color (low to high), zero padded
    input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // pixel_x, pixel_y, pixel_addr, out_color (low to high), zero padded
    output logic [((2*COORD_BITS+ADDR_BITS+COLOR_BITS+7)/8)*8-1:0] m_tdata,
    // no_pixel, off_screen (low to high)
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);

    localparam int C          = COORD_BITS;
    localparam int OUT_DATA_W = ((2*C + ADDR_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int CMD_W      = CMD_FLAG_BITS + 6*C + COLOR_BITS;

    logic [ADDR_BITS-1:0] base_reg;
    logic [SIZE_BITS-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= BASE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BUFFER_BASE:   base_reg   <= cfg_wdata;
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata[SIZE_BITS-1:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg_wdata[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // front to queue
    logic                  q_valid, q_ready;
    cmd_flags_t            q_flags;
    logic signed [C-1:0]   q_major_pos, q_major_stop, q_minor_pos, q_error;
    logic [C-1:0]          q_major_delta, q_minor_delta;
    logic [COLOR_BITS-1:0] q_color;

    lps_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_req_type   (s_tuser),
        .in_start_x    ($signed(s_tdata[C-1:0])),
        .in_start_y    ($signed(s_tdata[2*C-1:C])),
        .in_end_x      ($signed(s_tdata[3*C-1:2*C])),
        .in_end_y      ($signed(s_tdata[4*C-1:3*C])),
        .in_color      (s_tdata[4*C+COLOR_BITS-1:4*C]),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_flags       (q_flags),
        .q_major_pos   (q_major_pos),
        .q_major_stop  (q_major_stop),
        .q_minor_pos   (q_minor_pos),
        .q_major_delta (q_major_delta),
        .q_minor_delta (q_minor_delta),
        .q_error       (q_error),
        .q_color       (q_color)
    );

    // queue to back
    logic             c_valid, c_ready;
    logic [CMD_W-1:0] c_data;
    cmd_flags_t       c_flags;

    lps_queue #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_valid),
        .wr_ready (q_ready),
        .wr_data  ({q_flags, q_major_pos, q_major_stop, q_minor_pos,
                    q_major_delta, q_minor_delta, q_error, q_color}),
        .rd_valid (c_valid),
        .rd_ready (c_ready),
        .rd_data  (c_data)
    );

    assign c_flags = c_data[CMD_W-1 -: CMD_FLAG_BITS];

    // back to pixel output
    logic                  p_valid, p_ready;
    logic signed [C-1:0]   p_x, p_y;
    logic [COLOR_BITS-1:0] p_color;
    pix_flags_t            p_flags;

    lps_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (c_valid),
        .cmd_ready       (c_ready),
        .cmd_flags       (c_flags),
        .cmd_major_pos   ($signed(c_data[COLOR_BITS+6*C-1 -: C])),
        .cmd_major_stop  ($signed(c_data[COLOR_BITS+5*C-1 -: C])),
        .cmd_minor_pos   ($signed(c_data[COLOR_BITS+4*C-1 -: C])),
        .cmd_major_delta (c_data[COLOR_BITS+3*C-1 -: C]),
        .cmd_minor_delta (c_data[COLOR_BITS+2*C-1 -: C]),
        .cmd_error       ($signed(c_data[COLOR_BITS+C-1 -: C])),
        .cmd_color       (c_data[COLOR_BITS-1:0]),
        .pix_valid       (p_valid),
        .pix_ready       (p_ready),
        .pix_x           (p_x),
        .pix_y           (p_y),
        .pix_color       (p_color),
        .pix_flags       (p_flags)
    );

    logic signed [C-1:0]   o_x, o_y;
    logic [ADDR_BITS-1:0]  o_addr;
    logic [COLOR_BITS-1:0] o_color;
    logic                  o_none, o_off;

    lps_pixel_out #(.COORD_BITS(COORD_BITS), .ROW_SHIFT(ROW_SHIFT)) u_pixel_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .buffer_base   (base_reg),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .in_valid      (p_valid),
        .in_ready      (p_ready),
        .in_x          (p_x),
        .in_y          (p_y),
        .in_color      (p_color),
        .in_flags      (p_flags),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_x         (o_x),
        .out_y         (o_y),
        .out_addr      (o_addr),
        .out_color     (o_color),
        .out_last      (m_tlast),
        .out_none      (o_none),
        .out_off       (o_off)
    );

    assign m_tdata = OUT_DATA_W'({o_color, o_addr, o_y, o_x});
    assign m_tuser = {o_off, o_none};

`include "line_pixel_stepper_defines.svh"

    `LPS_ASSERT_NOW(a_empty_line_equal_ends, q_valid && q_flags.is_start && !q_flags.active, q_major_pos == q_major_stop, "empty line decoded with unequal major ends")
    `LPS_ASSERT_NOW(a_active_line_ordered, q_valid && q_flags.is_start && q_flags.active, q_major_pos < q_major_stop, "active line not ordered along major axis")
    `LPS_ASSERT_NOW(a_minor_not_above_major, q_valid && q_flags.is_start, q_minor_delta <= q_major_delta, "minor delta exceeds major delta")
    `LPS_ASSERT_NOW(a_no_pixel_zero_fields, m_tvalid && m_tuser[0], (m_tdata == '0) && !m_tlast && !m_tuser[1], "no-pixel result carries nonzero fields")
    `LPS_ASSERT_NEXT(a_front_holds_request, s_tvalid && s_tready, q_valid, "accepted request missing from front register")

endmodule

// ----- tb/lps_pixel_checker.sv -----
// Scoreboard for the line pixel stepper: watches the config port and both stream channels.
// Predicts one pixel result per request transaction and compares in order; needs lps_pkg.
module lps_pixel_checker
    import lps_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ADDR_BITS-1:0]    cfg_wdata,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [63:0]             s_tdata,
    input  logic                    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [71:0]             m_tdata,
    input  logic [1:0]              m_tuser,
    input  logic                    m_tlast,
    output int                      fail_count,
    output int                      pending_count,
    output int                      pixel_count,
    output int                      empty_count,
    output int                      offscreen_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_BITS_DEF;

    typedef struct packed {
        logic [CW-1:0]         x;
        logic [CW-1:0]         y;
        logic [ADDR_BITS-1:0]  addr;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
        logic                  none;
        logic                  off;
    } pixel_t;

    pixel_t pending_pixels[$];

    // configuration copy
    logic [ADDR_BITS-1:0] base_reg;
    logic [SIZE_BITS-1:0] width_reg;
    logic [SIZE_BITS-1:0] height_reg;

    // line walker state
    bit                    active;
    bit                    steep;
    int                    maj_pos;
    int                    maj_stop;
    int                    min_pos;
    int                    err_acc;
    int                    maj_delta;
    int                    min_delta;
    bit                    dir_neg;
    logic [COLOR_BITS-1:0] color_q;

    function automatic int sext_coord(logic [CW-1:0] v);
        return int'($signed(v));
    endfunction

    function automatic int abs_int(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int wrap_coord(int v, int size);
        if (v < 0) v += size;
        if (v >= size) v -= size;
        return v;
    endfunction

    function automatic void show_mismatch(pixel_t e, pixel_t g);
        $display("%0t: pixel mismatch exp x=%h y=%h addr=%h col=%h last=%b none=%b off=%b",
                 $time, e.x, e.y, e.addr, e.color, e.last, e.none, e.off);
        $display("%0t:                got x=%h y=%h addr=%h col=%h last=%b none=%b off=%b",
                 $time, g.x, g.y, g.addr, g.color, g.last, g.none, g.off);
    endfunction

    task automatic clear_line();
        active    = 0;
        steep     = 0;
        maj_pos   = 0;
        maj_stop  = 0;
        min_pos   = 0;
        err_acc   = 0;
        maj_delta = 0;
        min_delta = 0;
        dir_neg   = 0;
        color_q   = '0;
    endtask

    task automatic rasterize_step(input logic req, input logic [63:0] d, output pixel_t p);
        int ax, ay, bx, by, t, px, py, w, h;
        bit st;
        if (req == REQ_START) begin
            ax = sext_coord(d[11:0]);
            ay = sext_coord(d[23:12]);
            bx = sext_coord(d[35:24]);
            by = sext_coord(d[47:36]);
            st = abs_int(by - ay) > abs_int(bx - ax);
            if (st) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            steep     = st;
            maj_pos   = ax;
            maj_stop  = bx;
            min_pos   = ay;
            maj_delta = bx - ax;
            min_delta = abs_int(by - ay);
            err_acc   = -(maj_delta / 2);
            dir_neg   = !(ay < by);
            color_q   = d[63:48];
            active    = ax < bx;
        end
        p = '0;
        if (!active) begin
            p.none = 1'b1;
        end else begin
            w  = int'(width_reg);
            h  = int'(height_reg);
            px = wrap_coord(steep ? min_pos : maj_pos, w);
            py = wrap_coord(steep ? maj_pos : min_pos, h);
            p.x     = CW'(px);
            p.y     = CW'(py);
            p.addr  = base_reg + 32'(py << ROW_SHIFT_DEF) + 32'(px << 1);
            p.color = color_q;
            p.last  = (maj_pos + 1 >= maj_stop);
            p.off   = (px < 0) || (px >= w) || (py < 0) || (py >= h);
            // one step along the major axis
            err_acc += min_delta;
            if (err_acc > 0) begin
                min_pos += dir_neg ? -1 : 1;
                err_acc -= maj_delta;
            end
            maj_pos += 1;
            if (maj_pos >= maj_stop) active = 0;
        end
    endtask

    always @(posedge aclk) begin
        pixel_t exp_px, got_px;
        if (!aresetn) begin
            base_reg   = BASE_RESET;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            clear_line();
            pending_pixels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BUFFER_BASE:   base_reg   = cfg_wdata;
                    REG_SCREEN_WIDTH:  width_reg  = cfg_wdata[SIZE_BITS-1:0];
                    REG_SCREEN_HEIGHT: height_reg = cfg_wdata[SIZE_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                rasterize_step(s_tuser, s_tdata, exp_px);
                pending_pixels.push_back(exp_px);
            end
            if (m_tvalid && m_tready) begin
                got_px.x     = m_tdata[11:0];
                got_px.y     = m_tdata[23:12];
                got_px.addr  = m_tdata[55:24];
                got_px.color = m_tdata[71:56];
                got_px.last  = m_tlast;
                got_px.none  = m_tuser[0];
                got_px.off   = m_tuser[1];
                if (pending_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result transaction %h", $time, got_px);
                end else begin
                    exp_px = pending_pixels.pop_front();
                    if (exp_px.none) empty_count++;
                    else pixel_count++;
                    if (exp_px.off) offscreen_count++;
                    if (got_px !== exp_px) begin
                        fail_count++;
                        if (fail_count <= 10)
                            show_mismatch(exp_px, got_px);
                    end
                end
            end
        end
        pending_count = pending_pixels.size();
    end

    initial begin
        fail_count      = 0;
        pending_count   = 0;
        pixel_count     = 0;
        empty_count     = 0;
        offscreen_count = 0;
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the line pixel stepper testbench: clock, reset, config writes and stream stimulus.
// Depends on lps_pkg, line_pixel_stepper and lps_pixel_checker.
module tb_top;
    import lps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SEG_ITEMS    = 105;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [ADDR_BITS-1:0]    cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [63:0]             s_tdata   = '0;
    logic                    s_tuser   = REQ_START;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [71:0]             m_tdata;
    logic [1:0]              m_tuser;
    logic                    m_tlast;

    int fail_count, pending_count, pixel_count, empty_count, offscreen_count;

    int  send_idle_pct = 35;
    int  recv_idle_pct = 66;
    bit  hold_req      = 0;
    bit  hold_done     = 0;
    int  hold_left     = 0;
    int  items_sent    = 0;
    int  lines_started = 0;
    int  stuck_cycles  = 0;

    line_pixel_stepper dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    lps_pixel_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_count(pending_count), .pixel_count(pixel_count),
        .empty_count(empty_count), .offscreen_count(offscreen_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random back-pressure plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_req(input logic kind, input logic [63:0] payload);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                             input logic [15:0] color, input int n_next);
        lines_started++;
        send_req(REQ_START, {color, 12'(ey), 12'(ex), 12'(sy), 12'(sx)});
        repeat (n_next) send_req(REQ_NEXT, {$urandom, $urandom});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_regs(input logic [31:0] base, input logic [31:0] w,
                              input logic [31:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BUFFER_BASE;
        cfg_wdata <= base;
        @(negedge aclk);
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_traffic(input int count);
        int start_cnt, pick, reach, sx, sy, ex, ey, dx, dy, major, n_next;
        start_cnt = items_sent;
        while (items_sent - start_cnt < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                // short well-formed line, walked to its end most of the time
                reach = ($urandom_range(0, 9) == 0) ? 40 : 12;
                sx = $urandom_range(0, 1) ? int'($urandom_range(0, 4095)) : $urandom_range(0, 600);
                sy = $urandom_range(0, 1) ? int'($urandom_range(0, 4095)) : $urandom_range(0, 1100);
                ex = sx + int'($urandom_range(0, 2 * reach)) - reach;
                ey = sy + int'($urandom_range(0, 2 * reach)) - reach;
                dx = int'($signed(12'(ex))) - int'($signed(12'(sx)));
                dy = int'($signed(12'(ey))) - int'($signed(12'(sy)));
                dx = (dx < 0) ? -dx : dx;
                dy = (dy < 0) ? -dy : dy;
                major = (dx > dy) ? dx : dy;
                n_next = (major > 0) ? major - 1 + $urandom_range(0, 1) : $urandom_range(0, 1);
                if (n_next > 60) n_next = $urandom_range(0, 60);
                if ($urandom_range(0, 9) == 0) n_next = $urandom_range(0, n_next);
                send_line(sx, sy, ex, ey, 16'($urandom), n_next);
            end else if (pick < 92) begin
                send_line($urandom, $urandom, $urandom, $urandom, 16'($urandom),
                          $urandom_range(0, 3));
            end else begin
                repeat ($urandom_range(1, 3)) send_req(REQ_NEXT, {$urandom, $urandom});
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at reset configuration (320 x 240)
        send_req(REQ_NEXT, 64'hFFFF_FFFF_FFFF_FFFF);       // no line active yet
        send_line(0, 0, 0, 0, 16'hFFFF, 1);                 // empty line, then stray next
        send_line(10, 20, 14, 22, 16'h1234, 4);             // shallow, runs one past the end
        send_line(5, 30, 8, 25, 16'hA5A5, 4);               // steep, reversed, minor falling
        send_line(-2048, 2047, 2047, -2048, 16'hFFFF, 2);   // extremes, off screen
        send_line(2047, -2048, -2048, 2047, 16'h0000, 1);
        send_line(-1, -1, -1, 3, 16'h5A5A, 1);              // negative wraps to the right edge
        send_line(400, 300, 401, 300, 16'h8001, 1);         // single pixel, wraps both axes
        drain();

        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: write_regs(32'h0, 32'd512, 32'd1023);
                1: write_regs(32'hFFFF_FFFF, 32'd1, 32'd1);
                2: write_regs($urandom, 32'd0, 32'd0);
                3: write_regs($urandom, $urandom_range(1, 1023), $urandom_range(1, 1023));
                4: write_regs(BASE_RESET, WIDTH_RESET, HEIGHT_RESET);
                default: write_regs($urandom, 32'h3FF, 32'h3FF);
            endcase
            if (seg < 2) begin
                send_idle_pct = 35;
                recv_idle_pct = 66;
            end else if (seg < 4) begin
                send_idle_pct = 66;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 4) hold_req = 1;
            random_traffic(SEG_ITEMS);
            drain();
        end

        $display("Sent %0d requests over %0d lines under 7 register settings",
                 items_sent, lines_started);
        $display("Results: %0d pixels (%0d off screen), %0d without a pixel",
                 pixel_count, offscreen_count, empty_count);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_front.sv
rtl/lps_queue.sv
rtl/lps_back.sv
rtl/lps_pixel_out.sv
rtl/line_pixel_stepper.sv
tb/lps_pixel_checker.sv
tb/tb_top.sv
